@@ hdl/lwi_pkg.sv @@
// ----------------------------------------------------------------------------
// lwi_pkg
// Shared types and constants of the looped waypoint interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package lwi_pkg;

	localparam int MAX_WAYPOINTS = 64;
	localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
	localparam int TIME_W        = 32;
	localparam int ANGLE_W       = 16;
	localparam int DIFF_W        = ANGLE_W + 1;
	localparam int PROD_W        = DIFF_W + TIME_W + 1;
	localparam int DVD_W         = ANGLE_W + TIME_W;
	localparam int DIV_STEPS     = DVD_W;
	localparam int STEP_W        = $clog2(DIV_STEPS + 1);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_ZERO_DUR = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_SCAN0,
		S_SCAN,
		S_MUL,
		S_DIVST,
		S_DIV,
		S_RES
	} state_t;

	typedef struct packed {
		kind_t                     kind;
		logic [TIME_W-1:0]         time_ms;
		logic signed [ANGLE_W-1:0] gamma_angle;
		logic signed [ANGLE_W-1:0] theta_angle;
		logic                      last_waypoint;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0]         time_ms;
		logic signed [ANGLE_W-1:0] gamma;
		logic signed [ANGLE_W-1:0] theta;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DVD_W-1:0]  quotient;
		logic [TIME_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ hdl/lwi_ram.sv @@
// ----------------------------------------------------------------------------
// lwi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lwi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/lwi_front.sv @@
// ----------------------------------------------------------------------------
// lwi_front
// Input side: accept transactions, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module lwi_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [63:0]   in_data,
	input  wire logic          in_user,
	input  wire logic          in_last,
	output logic               q_valid,
	output lwi_pkg::item_t     q_item,
	input  wire logic          q_pop
);

	lwi_pkg::item_t                   buf_q [lwi_pkg::QUEUE_DEPTH];
	logic [lwi_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [lwi_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [lwi_pkg::QCNT_W-1:0]       cnt_q;
	lwi_pkg::item_t                   item_d;
	logic                             push;
	logic                             pop;

	assign in_ready = (cnt_q != lwi_pkg::QCNT_W'(lwi_pkg::QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = buf_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_comb begin
		item_d.kind          = in_user ? lwi_pkg::KIND_QUERY : lwi_pkg::KIND_LOAD;
		item_d.time_ms       = in_data[31:0];
		item_d.gamma_angle   = in_data[47:32];
		item_d.theta_angle   = in_data[63:48];
		item_d.last_waypoint = in_last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/lwi_div.sv @@
// ----------------------------------------------------------------------------
// lwi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lwi_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  lwi_pkg::div_req_t  req,
	output lwi_pkg::div_rsp_t  rsp
);

	logic [lwi_pkg::DVD_W-1:0]  quo_q;
	logic [lwi_pkg::TIME_W-1:0] rem_q;
	logic [lwi_pkg::TIME_W-1:0] dvs_q;
	logic [lwi_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lwi_pkg::TIME_W:0]   trial;
	logic                       ge;

	assign trial = {rem_q, quo_q[lwi_pkg::DVD_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[lwi_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? lwi_pkg::TIME_W'(trial - {1'b0, dvs_q}) : trial[lwi_pkg::TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == lwi_pkg::STEP_W'(lwi_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp.busy      = busy_q;
		rsp.done      = done_q;
		rsp.quotient  = quo_q;
		rsp.remainder = rem_q;
	end

endmodule
`default_nettype wire

@@ hdl/lwi_back.sv @@
// ----------------------------------------------------------------------------
// lwi_back
// Back end: waypoint table, wrap, segment search and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module lwi_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  lwi_pkg::item_t   q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_data,
	output logic [1:0]       out_user
);

	lwi_pkg::state_t                   state_q, state_d;
	logic [lwi_pkg::CNT_W-1:0]         count_q;
	logic                              complete_q;
	logic [lwi_pkg::TIME_W-1:0]        total_q;
	logic [lwi_pkg::TIME_W-1:0]        last_time_q;
	logic [lwi_pkg::TIME_W-1:0]        wrapped_q;
	lwi_pkg::entry_t                   prev_q;
	lwi_pkg::entry_t                   cur_q;
	logic [lwi_pkg::CNT_W-1:0]         j_q;
	logic signed [lwi_pkg::PROD_W-1:0] prod_g_q, prod_t_q;
	logic [lwi_pkg::TIME_W-1:0]        dur_q;
	logic [lwi_pkg::TIME_W-1:0]        res_wrapped_q;
	logic [lwi_pkg::ANGLE_W-1:0]       res_g_q, res_t_q;
	lwi_pkg::status_t                  res_status_q;
	logic                              out_valid_q;
	logic [63:0]                       out_data_q;
	logic [1:0]                        out_user_q;

	logic [lwi_pkg::CNT_W-1:0]         cnt_eff;
	logic                              has_room;
	logic                              ram_we;
	logic [lwi_pkg::ADDR_W-1:0]        ram_raddr;
	lwi_pkg::entry_t                   ram_wdata, ram_rdata;
	lwi_pkg::div_req_t                 req_g, req_t;
	lwi_pkg::div_rsp_t                 rsp_g, rsp_t;
	logic signed [lwi_pkg::DIFF_W-1:0] diff_g, diff_t;
	logic signed [lwi_pkg::PROD_W-1:0] prod_g, prod_t;
	logic [lwi_pkg::PROD_W-1:0]        mag_g, mag_t;
	logic [lwi_pkg::DVD_W-1:0]         qs_g, qs_t;
	logic                              is_load, is_query, q_err_empty, q_err_zero;
	logic                              scan_end, scan_adv;

	function automatic logic signed [lwi_pkg::DIFF_W-1:0] DIFF_EXT(
		input logic [lwi_pkg::ANGLE_W-1:0] a
	);
		return {a[lwi_pkg::ANGLE_W-1], a};
	endfunction

	assign cnt_eff  = complete_q ? '0 : count_q;
	assign has_room = (cnt_eff < lwi_pkg::CNT_W'(lwi_pkg::MAX_WAYPOINTS));
	assign is_load  = q_valid && (q_item.kind == lwi_pkg::KIND_LOAD);
	assign is_query = q_valid && (q_item.kind == lwi_pkg::KIND_QUERY);
	assign q_err_empty = !complete_q || (count_q == '0);
	assign q_err_zero  = (total_q == '0);
	assign scan_end = (j_q >= count_q);
	assign scan_adv = (ram_rdata.time_ms < wrapped_q);

	always_comb begin
		ram_wdata.time_ms = q_item.time_ms;
		ram_wdata.gamma   = q_item.gamma_angle;
		ram_wdata.theta   = q_item.theta_angle;
	end

	lwi_ram #(
		.WIDTH (lwi_pkg::ENTRY_W),
		.DEPTH (lwi_pkg::MAX_WAYPOINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_eff[lwi_pkg::ADDR_W-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lwi_div u_div_g (.clk(clk), .arst_n(arst_n), .req(req_g), .rsp(rsp_g));
	lwi_div u_div_t (.clk(clk), .arst_n(arst_n), .req(req_t), .rsp(rsp_t));

	assign diff_g = DIFF_EXT(cur_q.gamma) - DIFF_EXT(prev_q.gamma);
	assign diff_t = DIFF_EXT(cur_q.theta) - DIFF_EXT(prev_q.theta);
	assign prod_g = diff_g * $signed({1'b0, wrapped_q - prev_q.time_ms});
	assign prod_t = diff_t * $signed({1'b0, wrapped_q - prev_q.time_ms});
	assign mag_g  = prod_g_q[lwi_pkg::PROD_W-1] ? lwi_pkg::PROD_W'(-prod_g_q) : prod_g_q;
	assign mag_t  = prod_t_q[lwi_pkg::PROD_W-1] ? lwi_pkg::PROD_W'(-prod_t_q) : prod_t_q;
	assign qs_g   = prod_g_q[lwi_pkg::PROD_W-1] ? -rsp_g.quotient : rsp_g.quotient;
	assign qs_t   = prod_t_q[lwi_pkg::PROD_W-1] ? -rsp_t.quotient : rsp_t.quotient;

	always_comb begin
		state_d        = state_q;
		q_pop          = 1'b0;
		ram_we         = 1'b0;
		ram_raddr      = j_q[lwi_pkg::ADDR_W-1:0] + 1'b1;
		req_g.start    = 1'b0;
		req_g.dividend = mag_g[lwi_pkg::DVD_W-1:0];
		req_g.divisor  = dur_q;
		req_t.start    = 1'b0;
		req_t.dividend = mag_t[lwi_pkg::DVD_W-1:0];
		req_t.divisor  = dur_q;
		unique case (state_q)
			lwi_pkg::S_IDLE: begin
				if (is_load) begin
					q_pop  = 1'b1;
					ram_we = has_room;
				end else if (is_query) begin
					q_pop = 1'b1;
					if (q_err_empty || q_err_zero) begin
						state_d = lwi_pkg::S_RES;
					end else begin
						req_g.start    = 1'b1;
						req_g.dividend = lwi_pkg::DVD_W'(q_item.time_ms);
						req_g.divisor  = total_q;
						state_d        = lwi_pkg::S_MOD;
					end
				end
			end
			lwi_pkg::S_MOD: begin
				ram_raddr = '0;
				if (rsp_g.done) begin
					state_d = lwi_pkg::S_SCAN0;
				end
			end
			lwi_pkg::S_SCAN0: begin
				ram_raddr = lwi_pkg::ADDR_W'(1);
				state_d   = lwi_pkg::S_SCAN;
			end
			lwi_pkg::S_SCAN: begin
				ram_raddr = lwi_pkg::ADDR_W'(j_q + 1'b1);
				if (scan_end) begin
					state_d = lwi_pkg::S_RES;
				end else if (!scan_adv) begin
					if (wrapped_q < prev_q.time_ms || ram_rdata.time_ms <= prev_q.time_ms) begin
						state_d = lwi_pkg::S_RES;
					end else begin
						state_d = lwi_pkg::S_MUL;
					end
				end
			end
			lwi_pkg::S_MUL: begin
				state_d = lwi_pkg::S_DIVST;
			end
			lwi_pkg::S_DIVST: begin
				req_g.start = 1'b1;
				req_t.start = 1'b1;
				state_d     = lwi_pkg::S_DIV;
			end
			lwi_pkg::S_DIV: begin
				if (rsp_g.done) begin
					state_d = lwi_pkg::S_RES;
				end
			end
			lwi_pkg::S_RES: begin
				if (!out_valid_q || out_ready) begin
					state_d = lwi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lwi_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lwi_pkg::S_IDLE;
			count_q     <= '0;
			complete_q  <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lwi_pkg::S_IDLE && is_load) begin
				count_q    <= has_room ? cnt_eff + 1'b1 : cnt_eff;
				complete_q <= q_item.last_waypoint;
				if (q_item.last_waypoint) begin
					total_q <= has_room ? q_item.time_ms : last_time_q;
				end
			end
			if (state_q == lwi_pkg::S_RES && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lwi_pkg::S_IDLE: begin
				if (is_load && has_room) begin
					last_time_q <= q_item.time_ms;
				end
				res_wrapped_q <= '0;
				res_g_q       <= '0;
				res_t_q       <= '0;
				res_status_q  <= q_err_empty ? lwi_pkg::STATUS_EMPTY : lwi_pkg::STATUS_ZERO_DUR;
			end
			lwi_pkg::S_MOD: begin
				wrapped_q <= rsp_g.remainder;
			end
			lwi_pkg::S_SCAN0: begin
				prev_q        <= ram_rdata;
				j_q           <= lwi_pkg::CNT_W'(1);
				res_wrapped_q <= wrapped_q;
				res_status_q  <= lwi_pkg::STATUS_OK;
			end
			lwi_pkg::S_SCAN: begin
				res_g_q <= prev_q.gamma;
				res_t_q <= prev_q.theta;
				if (!scan_end && scan_adv) begin
					prev_q  <= ram_rdata;
					j_q     <= j_q + 1'b1;
					res_g_q <= ram_rdata.gamma;
					res_t_q <= ram_rdata.theta;
				end else if (!scan_end) begin
					cur_q <= ram_rdata;
				end
			end
			lwi_pkg::S_MUL: begin
				prod_g_q <= prod_g;
				prod_t_q <= prod_t;
				dur_q    <= cur_q.time_ms - prev_q.time_ms;
			end
			lwi_pkg::S_DIVST: begin
			end
			lwi_pkg::S_DIV: begin
				if (rsp_g.done) begin
					res_g_q <= prev_q.gamma + qs_g[lwi_pkg::ANGLE_W-1:0];
					res_t_q <= prev_q.theta + qs_t[lwi_pkg::ANGLE_W-1:0];
				end
			end
			lwi_pkg::S_RES: begin
				if (!out_valid_q || out_ready) begin
					out_data_q <= {res_t_q, res_g_q, res_wrapped_q};
					out_user_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lwi_pkg::CNT_W'(lwi_pkg::MAX_WAYPOINTS))
		else $error("waypoint count beyond table size");

	a_mod_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lwi_pkg::S_MOD) |-> (complete_q && total_q != '0 && count_q != '0))
		else $error("wrap started on unusable table");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lwi_pkg::S_DIV) |-> (rsp_g.done == rsp_t.done))
		else $error("angle dividers out of step");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lwi_pkg::S_SCAN) |-> (j_q != '0))
		else $error("scan index at first waypoint");

endmodule
`default_nettype wire

@@ hdl/looped_waypoint_interpolator.sv @@
// ----------------------------------------------------------------------------
// looped_waypoint_interpolator
// Waypoint table with looped piecewise linear lookup of gamma and theta.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                      tuser    tlast
// s_axis   in   time_ms[31:0] gamma[47:32] theta[63:48]  opcode   last_waypoint
// m_axis   out  wrapped[31:0] gamma[47:32] theta[63:48]  status   -
//
// Load: handled in the back end's idle state. Query on a bad table: straight to the
// result state. Query: wrap divider, then table scan (N stored waypoints, one RAM
// read a cycle), then interpolation divider.
// The two-entry input queue takes transactions while the back end works.
// Reset clears counts and flags only; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module looped_waypoint_interpolator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // time_ms, gamma_angle, theta_angle
	input  wire logic        s_axis_tuser,  // opcode
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // wrapped_time, gamma_out, theta_out
	output logic [1:0]       m_axis_tuser   // status
);

	logic           q_valid;
	logic           q_pop;
	lwi_pkg::item_t q_item;

	lwi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	lwi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
`default_nettype wire

@@ tb/sv/looped_waypoint_interpolator_test.sv @@
// ----------------------------------------------------------------------------
// looped_waypoint_interpolator_test
// Loads waypoint tables and queries the looped trajectory, predicting each
// interpolated result and comparing it with every output transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module looped_waypoint_interpolator_test;

	class trajectory_scoreboard;
		logic [31:0]        wp_time[lwi_pkg::MAX_WAYPOINTS];
		logic signed [15:0] wp_gamma[lwi_pkg::MAX_WAYPOINTS];
		logic signed [15:0] wp_theta[lwi_pkg::MAX_WAYPOINTS];
		int unsigned        wp_count;
		bit                 complete;
		logic [31:0]        loop_len;
		logic [65:0]        pending[$];
		int                 errors;

		function void clear();
			wp_count = 0;
			complete = 0;
			loop_len = 0;
			errors = 0;
			pending.delete();
		endfunction

		function void enqueue(logic [65:0] e);
			pending = {pending, e};
		endfunction

		function logic signed [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
				longint unsigned offs, longint unsigned dur);
			longint d;
			longint p;
			d = longint'(b) - longint'(a);
			p = d * longint'(offs);
			return a + 16'(p / longint'(dur));
		endfunction

		function void note_input(lwi_pkg::kind_t kind, logic [31:0] t, logic signed [15:0] g,
				logic signed [15:0] th, bit last);
			logic [31:0]        w;
			int unsigned        i;
			logic signed [15:0] go;
			logic signed [15:0] to;
			if (kind == lwi_pkg::KIND_LOAD) begin
				if (complete) begin
					wp_count = 0;
					complete = 0;
				end
				if (wp_count < lwi_pkg::MAX_WAYPOINTS) begin
					wp_time[wp_count] = t;
					wp_gamma[wp_count] = g;
					wp_theta[wp_count] = th;
					wp_count++;
				end
				if (last) begin
					complete = 1;
					loop_len = wp_time[wp_count-1];
				end
				return;
			end
			if (!complete || wp_count == 0) begin
				enqueue({lwi_pkg::STATUS_EMPTY, 64'd0});
				return;
			end
			if (loop_len == 0) begin
				enqueue({lwi_pkg::STATUS_ZERO_DUR, 64'd0});
				return;
			end
			w = t % loop_len;
			i = 0;
			while (i + 1 < wp_count && wp_time[i+1] < w)
				i++;
			if (i + 1 >= wp_count) begin
				go = wp_gamma[wp_count-1];
				to = wp_theta[wp_count-1];
			end else if (w < wp_time[i] || wp_time[i+1] <= wp_time[i]) begin
				go = wp_gamma[i];
				to = wp_theta[i];
			end else begin
				go = blend(wp_gamma[i], wp_gamma[i+1], w - wp_time[i], wp_time[i+1] - wp_time[i]);
				to = blend(wp_theta[i], wp_theta[i+1], w - wp_time[i], wp_time[i+1] - wp_time[i]);
			end
			enqueue({lwi_pkg::STATUS_OK, to, go, w});
		endfunction

		function void check_result(logic [63:0] data, logic [1:0] st);
			logic [65:0] e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result data=%h status=%0d", $time, data, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e[65:64] !== st) begin
				$display("%0t: status expected %0d actual %0d", $time, e[65:64], st);
				errors++;
			end
			if (e[31:0] !== data[31:0]) begin
				$display("%0t: wrapped expected %0d actual %0d", $time, e[31:0], data[31:0]);
				errors++;
			end
			if (e[47:32] !== data[47:32]) begin
				$display("%0t: gamma expected %0d actual %0d", $time,
					$signed(e[47:32]), $signed(data[47:32]));
				errors++;
			end
			if (e[63:48] !== data[63:48]) begin
				$display("%0t: theta expected %0d actual %0d", $time,
					$signed(e[63:48]), $signed(data[63:48]));
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	trajectory_scoreboard sb;
	longint unsigned      cycles;
	bit                   hold_off;
	logic [31:0]          span;

	looped_waypoint_interpolator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic send(lwi_pkg::kind_t kind, logic [31:0] t, logic [15:0] g, logic [15:0] th,
			bit last);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 1))
			gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {th, g, t};
		s_axis_tuser <= kind;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(kind, t, g, th, last);
	endtask

	task automatic query(logic [31:0] t);
		send(lwi_pkg::KIND_QUERY, t, 16'($urandom), 16'($urandom), 1'($urandom));
	endtask

	task automatic load_table(int n, logic [31:0] step_max, bit ordered);
		logic [31:0] t;
		t = $urandom_range(0, step_max);
		for (int k = 0; k < n; k++) begin
			send(lwi_pkg::KIND_LOAD, ordered ? t : 32'($urandom_range(0, step_max * 4)),
				16'($urandom), 16'($urandom), k == n - 1);
			t = t + $urandom_range(0, step_max);
		end
		span = t;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int wait_cycles;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (2000) @(posedge clk);
				hold_off = 0;
			end
			wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
			if (cycles > 60000 && cycles < 90000)
				wait_cycles = 0;
			if (wait_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles - 1) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("looped_waypoint_interpolator_test: errors");
			$finish;
		end
	end

	initial begin
		int n;
		sb = new();
		sb.clear();
		cycles = 0;
		hold_off = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, incomplete table, zero duration
		query(32'hFFFF_FFFF);
		send(lwi_pkg::KIND_LOAD, 32'd0, 16'h8000, 16'h7FFF, 1'b0);
		query(32'd5);
		send(lwi_pkg::KIND_LOAD, 32'd0, 16'h7FFF, 16'h8000, 1'b1);
		query(32'd7);
		// single point table
		send(lwi_pkg::KIND_LOAD, 32'd100, 16'h1234, 16'hFEDC, 1'b1);
		query(32'd250);
		// before first waypoint, extremes, zero-length segment, past end
		send(lwi_pkg::KIND_LOAD, 32'd50, 16'h8000, 16'h7FFF, 1'b0);
		send(lwi_pkg::KIND_LOAD, 32'd50, 16'h0000, 16'h0000, 1'b0);
		send(lwi_pkg::KIND_LOAD, 32'hFFFF_0000, 16'h7FFF, 16'h8000, 1'b0);
		send(lwi_pkg::KIND_LOAD, 32'hFFFF_FFFE, 16'h8000, 16'h7FFF, 1'b1);
		query(32'd10);
		query(32'd50);
		query(32'h8000_0000);
		query(32'hFFFF_FFFF);
		query(32'hFFFF_FFFD);
		// full table with overflow and late last mark
		for (int k = 0; k < lwi_pkg::MAX_WAYPOINTS + 2; k++)
			send(lwi_pkg::KIND_LOAD, 32'(k * 1000 + 3), 16'($urandom), 16'($urandom),
				k == lwi_pkg::MAX_WAYPOINTS + 1);
		query(32'd62500);
		query(32'd100000);
		drain();

		// long receiver hold-off while queries keep coming
		hold_off = 1;
		for (int k = 0; k < 6; k++)
			query($urandom);
		drain();

		for (int r = 0; r < 36; r++) begin
			case ($urandom_range(0, 9))
				0: n = $urandom_range(1, 2);
				1: n = lwi_pkg::MAX_WAYPOINTS + $urandom_range(0, 2);
				default: n = $urandom_range(2, 10);
			endcase
			case ($urandom_range(0, 7))
				0: load_table(n, 32'hFFFF_FFFF / (n + 1), 1'b1);
				1: load_table(n, 32'd1000, 1'b0);
				2: load_table(n, 32'd2, 1'b1);
				default: load_table(n, 32'd5000, 1'b1);
			endcase
			for (int q = 0; q < 9; q++) begin
				if ($urandom_range(0, 19) == 0)
					send(lwi_pkg::KIND_LOAD, $urandom, 16'($urandom), 16'($urandom), 1'b0);
				query($urandom_range(0, 3) == 0 ? $urandom :
					32'($urandom_range(0, (span > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : span * 2)));
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("looped_waypoint_interpolator_test: clean");
		else
			$display("looped_waypoint_interpolator_test: errors");
		$finish;
	end
endmodule
`default_nettype wire
